// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// same-cycle implication outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ddmc_pkg.sv =====
// shared types, constants and font table of the digit matrix counter
package ddmc_pkg;

  localparam int PIXEL_COUNT = 25;
  localparam int GRID_SIDE   = 5;
  localparam int DIGIT_COUNT = 10;
  localparam int QUEUE_DEPTH = 2;

  localparam int ACTION_W = 2;
  localparam int TIME_W   = 32;
  localparam int INDEX_W  = 5;
  localparam int COLOR_W  = 24;
  localparam int DIGIT_W  = 4;
  localparam int POS_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // event codes
  localparam logic [ACTION_W-1:0] ACT_UP   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DOWN = 2'd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DARK   = 2'd2;

  localparam logic [TIME_W-1:0]  RESET_WINDOW = 32'd200000;
  localparam logic [COLOR_W-1:0] RESET_LIT    = 24'h00FF00;
  localparam logic [COLOR_W-1:0] RESET_DARK   = 24'h000000;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'(DIGIT_COUNT - 1);
  localparam logic [POS_W-1:0]   POS_LAST   = 3'(GRID_SIDE - 1);
  localparam logic [INDEX_W-1:0] INDEX_LAST = 5'(PIXEL_COUNT - 1);

  // bit c of row r lights column c
  localparam logic [GRID_SIDE-1:0] FONT_ROWS [DIGIT_COUNT][GRID_SIDE] = '{
    '{5'h1F, 5'h11, 5'h11, 5'h11, 5'h1F},
    '{5'h00, 5'h00, 5'h1F, 5'h00, 5'h00},
    '{5'h1D, 5'h15, 5'h15, 5'h15, 5'h17},
    '{5'h11, 5'h15, 5'h15, 5'h15, 5'h1F},
    '{5'h07, 5'h04, 5'h04, 5'h04, 5'h1F},
    '{5'h17, 5'h15, 5'h15, 5'h15, 5'h1D},
    '{5'h1F, 5'h15, 5'h15, 5'h15, 5'h1D},
    '{5'h01, 5'h01, 5'h01, 5'h01, 5'h1F},
    '{5'h1F, 5'h15, 5'h15, 5'h15, 5'h1F},
    '{5'h17, 5'h15, 5'h15, 5'h15, 5'h1F}
  };

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
  } frame_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] lit;
    logic [COLOR_W-1:0] dark;
  } color_cfg_t;

endpackage

// ===== rtl/ddmc_if.sv =====
// button event and pixel channel interfaces
interface ddmc_evt_if;
  import ddmc_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [TIME_W-1:0]   timestamp_us;
  modport source (output valid, output action, output timestamp_us, input ready);
  modport sink   (input valid, input action, input timestamp_us, output ready);
endinterface

interface ddmc_pix_if;
  import ddmc_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] pixel_index;
  logic [COLOR_W-1:0] pixel_color;
  logic [DIGIT_W-1:0] shown_digit;
  logic               last_pixel;
  modport source (output valid, output pixel_index, output pixel_color,
                  output shown_digit, output last_pixel, input ready);
  modport sink   (input valid, input pixel_index, input pixel_color,
                  input shown_digit, input last_pixel, output ready);
endinterface

// ===== rtl/ddmc_front.sv =====
// event front end: debounce check and digit update
module ddmc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ddmc_evt_if.sink                       evt,
  input  logic [ddmc_pkg::TIME_W-1:0]    window_i,
  input  logic                           full_i,
  output logic                           push_o,
  output ddmc_pkg::frame_req_t           push_data_o
);
  import ddmc_pkg::*;

  logic [TIME_W-1:0]  last_q, last_d;
  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [TIME_W-1:0]  gap;
  logic               take;

  assign evt.ready = !full_i;
  assign gap       = evt.timestamp_us - last_q;
  assign take      = evt.valid && !full_i && (gap > window_i);

  always_comb begin
    last_d  = last_q;
    digit_d = digit_q;
    if (take) begin
      last_d = evt.timestamp_us;
      case (evt.action)
        ACT_UP:   digit_d = (digit_q == DIGIT_MAX) ? '0 : digit_q + 4'd1;
        ACT_DOWN: digit_d = (digit_q == '0) ? DIGIT_MAX : digit_q - 4'd1;
        default:  digit_d = digit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      digit_q <= '0;
    end else begin
      last_q  <= last_d;
      digit_q <= digit_d;
    end
  end

  assign push_o            = take;
  assign push_data_o.digit = digit_d;
endmodule

// ===== rtl/ddmc_queue.sv =====
// short frame request queue between front and back end
module ddmc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ddmc_pkg::frame_req_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output ddmc_pkg::frame_req_t pop_data_o,
  output logic                 empty_o
);
  import ddmc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_req_t       slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end
endmodule

// ===== rtl/ddmc_back.sv =====
// frame back end: walks the 5x5 font and drives the pixel output register
module ddmc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ddmc_pkg::color_cfg_t colors_i,
  input  logic                 empty_i,
  input  ddmc_pkg::frame_req_t pop_data_i,
  output logic                 pop_o,
  ddmc_pix_if.source           pix
);
  import ddmc_pkg::*;

  logic               active_q, active_d;
  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [POS_W-1:0]   row_q, row_d, col_q, col_d;
  logic [INDEX_W-1:0] idx_q, idx_d;
  logic               valid_q, valid_d;
  logic [INDEX_W-1:0] out_idx_q;
  logic [COLOR_W-1:0] out_color_q;
  logic [DIGIT_W-1:0] out_digit_q;
  logic               out_last_q;
  logic               adv, at_last, lit;
  logic [GRID_SIDE-1:0] row_bits;

  assign adv      = !valid_q || pix.ready;
  assign at_last  = (idx_q == INDEX_LAST);
  assign row_bits = FONT_ROWS[digit_q][row_q];
  assign lit      = row_bits[col_q];
  assign pop_o    = !empty_i && (!active_q || (adv && at_last));

  always_comb begin
    active_d = active_q;
    digit_d  = digit_q;
    row_d    = row_q;
    col_d    = col_q;
    idx_d    = idx_q;
    valid_d  = valid_q;
    if (adv) begin
      valid_d = active_q;
      if (active_q) begin
        idx_d = idx_q + 5'd1;
        if (col_q == POS_LAST) begin
          col_d = '0;
          row_d = row_q + 3'd1;
        end else begin
          col_d = col_q + 3'd1;
        end
        if (at_last) begin
          active_d = 1'b0;
        end
      end
    end
    if (pop_o) begin
      active_d = 1'b1;
      digit_d  = pop_data_i.digit;
      row_d    = '0;
      col_d    = '0;
      idx_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    row_q   <= row_d;
    col_q   <= col_d;
    idx_q   <= idx_d;
    if (adv && active_q) begin
      out_idx_q   <= idx_q;
      out_color_q <= lit ? colors_i.lit : colors_i.dark;
      out_digit_q <= digit_q;
      out_last_q  <= at_last;
    end
  end

  assign pix.valid       = valid_q;
  assign pix.pixel_index = out_idx_q;
  assign pix.pixel_color = out_color_q;
  assign pix.shown_digit = out_digit_q;
  assign pix.last_pixel  = out_last_q;
endmodule

// ===== rtl/debounced_digit_matrix_counter_unit.sv =====
// top level of the debounced up/down digit counter with 5x5 matrix output
// An accepted button event (one whose wrapping microsecond gap from the last
// accepted event exceeds the debounce window) steps the digit up or down, or
// just redraws it, and produces a 25-pixel frame, row by row, last pixel
// flagged. Rejected events produce nothing. The front end takes one event
// per cycle while its two-entry frame queue has room; the back end's pixel
// counter emits one pixel per cycle while the sink is ready, and frames
// follow without gaps. The frame request is queued and the pixel output is
// registered. Colors are read from the registers as pixels go out; write
// them only while the block is idle.
module debounced_digit_matrix_counter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ddmc_evt_if.sink                          evt_i,
  ddmc_pix_if.source                        pix_o,
  input  logic                              cfg_we_i,
  input  logic [ddmc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ddmc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ddmc_pkg::*;

  // configuration registers
  logic [TIME_W-1:0]  window_q;
  color_cfg_t         colors_q;

  // front to queue and queue to back
  logic       push, full, pop, empty;
  frame_req_t push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q      <= RESET_WINDOW;
      colors_q.lit  <= RESET_LIT;
      colors_q.dark <= RESET_DARK;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW: window_q      <= cfg_data_i;
        REG_LIT:    colors_q.lit  <= cfg_data_i[COLOR_W-1:0];
        REG_DARK:   colors_q.dark <= cfg_data_i[COLOR_W-1:0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // debounce and digit step
  ddmc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt         (evt_i),
    .window_i    (window_q),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // pending frames
  ddmc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // pixel generation
  ddmc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .colors_i   (colors_q),
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .pix        (pix_o)
  );
endmodule

// ===== rtl/ddmc_checker.sv =====
// port-level checks on the pixel output, bound to the top level
`include "assert_macros.svh"

module ddmc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           valid_i,
  input logic                           ready_i,
  input logic [ddmc_pkg::INDEX_W-1:0]   pixel_index_i,
  input logic [ddmc_pkg::DIGIT_W-1:0]   shown_digit_i,
  input logic                           last_pixel_i
);
  import ddmc_pkg::*;

  // a stalled pixel stays offered
  `ASSERT_PROP(a_hold, clk_i, rst_ni, (valid_i && !ready_i) |=> valid_i)
  // last flag sits on the final index only
  `ASSERT_IMPL(a_last, clk_i, rst_ni, valid_i, last_pixel_i == (pixel_index_i == INDEX_LAST))
  // shown digit stays decimal
  `ASSERT_IMPL(a_digit, clk_i, rst_ni, valid_i, shown_digit_i <= DIGIT_MAX)
  // a frame runs without gaps, index counting up, digit fixed
  `ASSERT_PROP(a_next, clk_i, rst_ni, (valid_i && ready_i && !last_pixel_i) |=> (valid_i && pixel_index_i == 5'($past(pixel_index_i) + 5'd1) && $stable(shown_digit_i)))
endmodule

bind debounced_digit_matrix_counter_unit ddmc_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (pix_o.valid),
  .ready_i       (pix_o.ready),
  .pixel_index_i (pix_o.pixel_index),
  .shown_digit_i (pix_o.shown_digit),
  .last_pixel_i  (pix_o.last_pixel)
);

// ===== tb/sv/ddmc_frame_checker.sv =====
`timescale 1ns / 100ps
// watches the event and pixel channels, predicts each frame and checks every pixel
module ddmc_frame_checker
  import ddmc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ddmc_evt_if                   evt_mon,
  ddmc_pix_if                   pix_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           pixels_pending_o
);

  localparam logic [TIME_W-1:0]  BOOT_WINDOW_US = 32'd200000;
  localparam logic [COLOR_W-1:0] BOOT_LIT       = 24'h00FF00;
  localparam logic [COLOR_W-1:0] BOOT_DARK      = 24'h000000;
  localparam int                 MAX_REPORTS    = 10;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] color;
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } pixel_t;

  pixel_t             frame_q[$];
  logic [DIGIT_W-1:0] digit_now;
  logic [TIME_W-1:0]  last_taken_us;
  logic [TIME_W-1:0]  window_us;
  logic [COLOR_W-1:0] lit_color;
  logic [COLOR_W-1:0] dark_color;
  int unsigned        mismatches;

  // 5x5 glyph, bit r*5+c lights row r column c
  function automatic logic [24:0] glyph_of(input logic [DIGIT_W-1:0] d);
    case (d)
      4'd0:    return {5'h1F, 5'h11, 5'h11, 5'h11, 5'h1F};
      4'd1:    return {5'h00, 5'h00, 5'h1F, 5'h00, 5'h00};
      4'd2:    return {5'h17, 5'h15, 5'h15, 5'h15, 5'h1D};
      4'd3:    return {5'h1F, 5'h15, 5'h15, 5'h15, 5'h11};
      4'd4:    return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h07};
      4'd5:    return {5'h1D, 5'h15, 5'h15, 5'h15, 5'h17};
      4'd6:    return {5'h1D, 5'h15, 5'h15, 5'h15, 5'h1F};
      4'd7:    return {5'h1F, 5'h01, 5'h01, 5'h01, 5'h01};
      4'd8:    return {5'h1F, 5'h15, 5'h15, 5'h15, 5'h1F};
      4'd9:    return {5'h1F, 5'h15, 5'h15, 5'h15, 5'h17};
      default: return '0;
    endcase
  endfunction

  // debounce, step the digit and queue the 25 pixels of its glyph
  task automatic queue_digit_frame(input logic [ACTION_W-1:0] act,
                                   input logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0] gap_us;
    logic [24:0]       glyph;
    pixel_t            px;
    gap_us = stamp - last_taken_us;
    if (gap_us > window_us) begin
      last_taken_us = stamp;
      case (act)
        ACT_UP:   digit_now = (digit_now == 4'd9) ? 4'd0 : digit_now + 4'd1;
        ACT_DOWN: digit_now = (digit_now == 4'd0) ? 4'd9 : digit_now - 4'd1;
        default:  ;
      endcase
      glyph = glyph_of(digit_now);
      for (int p = 0; p < 25; p++) begin
        px.index = 5'(p);
        px.color = glyph[p] ? lit_color : dark_color;
        px.digit = digit_now;
        px.last  = (p == 24);
        frame_q.push_back(px);
      end
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (frame_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected pixel: idx %0d color %06h digit %0d last %0b",
                 pix_mon.pixel_index, pix_mon.pixel_color, pix_mon.shown_digit,
                 pix_mon.last_pixel);
    end else begin
      want = frame_q.pop_front();
      if (want.index !== pix_mon.pixel_index || want.color !== pix_mon.pixel_color ||
          want.digit !== pix_mon.shown_digit || want.last !== pix_mon.last_pixel) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("pixel mismatch: expected idx %0d color %06h digit %0d last %0b, %s",
                   want.index, want.color, want.digit, want.last, "got below");
        if (mismatches <= MAX_REPORTS)
          $display("  got idx %0d color %06h digit %0d last %0b",
                   pix_mon.pixel_index, pix_mon.pixel_color, pix_mon.shown_digit,
                   pix_mon.last_pixel);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q.delete();
      digit_now        = '0;
      last_taken_us    = '0;
      window_us        = BOOT_WINDOW_US;
      lit_color        = BOOT_LIT;
      dark_color       = BOOT_DARK;
      mismatches       = 0;
      mismatch_count_o <= 0;
      pixels_pending_o <= 0;
    end else begin
      if (pix_mon.valid && pix_mon.ready) check_pixel();
      if (evt_mon.valid && evt_mon.ready)
        queue_digit_frame(evt_mon.action, evt_mon.timestamp_us);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WINDOW: window_us  = cfg_data_i;
          REG_LIT:    lit_color  = cfg_data_i[COLOR_W-1:0];
          REG_DARK:   dark_color = cfg_data_i[COLOR_W-1:0];
          default:    ;
        endcase
      end
      mismatch_count_o <= mismatches;
      pixels_pending_o <= frame_q.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// top of the digit matrix counter testbench: clock, reset, stimulus and verdict
module testbench;
  import ddmc_pkg::*;

  // event codes the package leaves unnamed, and the register index past the last one
  localparam logic [ACTION_W-1:0]  ACT_REDRAW = 2'd2;
  localparam logic [ACTION_W-1:0]  ACT_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

  // rejected events may still sit in the front end when the last pixel leaves
  localparam int unsigned SETTLE_CYCLES = 8;
  // every pixel waiting out the longest stall, several times over
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned mismatches;
  int unsigned frames_pending;
  int unsigned cycle_count = 0;

  // stimulus-side copy of the window and the last accepted time, used only to
  // aim timestamps at the debounce boundary
  logic [TIME_W-1:0] cur_window = 32'd200000;
  logic [TIME_W-1:0] anchor_us  = '0;

  // calm stretches turn random idling off on one side
  bit sender_calm = 1'b0;
  bit sink_calm   = 1'b0;

  ddmc_evt_if evt_ch ();
  ddmc_pix_if pix_ch ();

  debounced_digit_matrix_counter_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt_ch),
    .pix_o      (pix_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  ddmc_frame_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .evt_mon          (evt_ch),
    .pix_mon          (pix_ch),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pixels_pending_o (frames_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // mostly no gap or a short one, now and then a long one
  function automatic int unsigned idle_gap(input bit calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // timestamp aimed relative to the last accepted event: mostly clear of the
  // window, some right at its edge, some inside it, a few anywhere on the timer
  function automatic logic [TIME_W-1:0] pick_stamp(input logic [TIME_W-1:0] anchor,
                                                   input logic [TIME_W-1:0] win);
    int unsigned       roll;
    logic [TIME_W-1:0] delta;
    roll = $urandom_range(0, 99);
    if (roll < 55)      delta = win + 32'd1 + 32'($urandom_range(0, 5000));
    else if (roll < 70) delta = win + 32'($urandom_range(0, 1));
    else if (roll < 88) delta = 32'($urandom_range(win, 0));
    else                return 32'($urandom);
    return anchor + delta;
  endfunction

  // pixel sink: random stalls on ready, with calm stretches
  initial begin : pixel_backpressure
    int unsigned stall;
    pix_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
      stall = idle_gap(sink_calm);
      if (stall != 0) begin
        pix_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pix_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // one event transaction; valid stays high when no gap follows
  task automatic send_event(input logic [ACTION_W-1:0] act, input logic [TIME_W-1:0] stamp);
    int unsigned gap;
    evt_ch.valid        <= 1'b1;
    evt_ch.action       <= act;
    evt_ch.timestamp_us <= stamp;
    @(posedge clk_i);
    while (!evt_ch.ready) @(posedge clk_i);
    gap = idle_gap(sender_calm);
    if (gap != 0) begin
      // junk payload while idle
      evt_ch.valid        <= 1'b0;
      evt_ch.action       <= 2'($urandom);
      evt_ch.timestamp_us <= 32'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic post_event(input logic [ACTION_W-1:0] act, input logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0] gap_us;
    gap_us = stamp - anchor_us;
    if (gap_us > cur_window) anchor_us = stamp;
    send_event(act, stamp);
  endtask

  // sender holds off until every pixel has come and the front end has settled
  task automatic drain_frames();
    evt_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (frames_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // back-to-back register writes, write enable held high throughout;
  // upper data bits of the color registers carry junk that must be dropped
  task automatic write_regs(input logic [TIME_W-1:0] win, input logic [COLOR_W-1:0] lit,
                            input logic [COLOR_W-1:0] dark, input bit poke_spare);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_WINDOW;
    cfg_data <= win;
    @(posedge clk_i);
    cfg_idx  <= REG_LIT;
    cfg_data <= {8'($urandom), lit};
    @(posedge clk_i);
    cfg_idx  <= REG_DARK;
    cfg_data <= {8'($urandom), dark};
    @(posedge clk_i);
    if (poke_spare) begin
      // index past the last register, must change nothing
      cfg_idx  <= REG_SPARE;
      cfg_data <= 32'($urandom);
      @(posedge clk_i);
    end
    cfg_we     <= 1'b0;
    cur_window = win;
  endtask

  task automatic run_random(input int unsigned count, input bit hold_midway);
    for (int unsigned k = 0; k < count; k++) begin
      if (hold_midway && k == count / 2) drain_frames();
      if ($urandom_range(0, 19) == 0) sender_calm = !sender_calm;
      post_event(2'($urandom_range(0, 3)), pick_stamp(anchor_us, cur_window));
    end
  endtask

  initial begin : stimulus
    evt_ch.valid        <= 1'b0;
    evt_ch.action       <= ACT_UP;
    evt_ch.timestamp_us <= '0;
    cfg_we              <= 1'b0;
    cfg_idx             <= REG_WINDOW;
    cfg_data            <= '0;
    rst_ni              <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset configuration (window 200000)
    post_event(ACT_UP,     32'd100);         // too early after reset
    post_event(ACT_UP,     32'd200000);      // gap equal to window, rejected
    post_event(ACT_DOWN,   32'd200001);      // accepted, 0 wraps to 9
    post_event(ACT_UP,     32'd400001);      // equal gap again
    post_event(ACT_UP,     32'd400002);      // 9 wraps to 0
    post_event(ACT_REDRAW, 32'd700002);      // redraw only
    post_event(ACT_SPARE,  32'd1000002);     // spare code redraws too
    post_event(ACT_DOWN,   32'd1300002);
    post_event(ACT_DOWN,   32'd1600002);
    post_event(ACT_UP,     32'd1900002);
    post_event(ACT_UP,     32'hFFFF_FFF0);   // near the top of the timer
    post_event(ACT_UP,     32'h0003_0D30);   // wrapped gap equal to window
    post_event(ACT_DOWN,   32'h0003_0D31);   // wrapped gap one past window
    post_event(ACT_UP,     32'hFFFF_FFFF);
    post_event(ACT_UP,     32'h0000_0000);   // wraps to a gap of one
    post_event(ACT_REDRAW, 32'h7FFF_FFFF);

    // zero window: anything but a repeated timestamp gets through
    drain_frames();
    write_regs(32'd0, 24'hFFFFFF, 24'h000000, 1'b0);
    run_random(40, 1'b0);

    // all-ones window: nothing can be accepted; colors swapped to extremes
    drain_frames();
    write_regs(32'hFFFF_FFFF, 24'h000000, 24'hFFFFFF, 1'b1);
    run_random(15, 1'b0);

    // short window, random colors, with a full hold-off halfway
    drain_frames();
    write_regs(32'($urandom_range(1, 2000)), 24'($urandom), 24'($urandom), 1'b0);
    run_random(130, 1'b1);

    // back to the power-on window
    drain_frames();
    write_regs(32'd200000, 24'($urandom), 24'($urandom), 1'b1);
    run_random(130, 1'b0);

    // arbitrary window anywhere in the 32-bit range, timer wraps often
    drain_frames();
    write_regs(32'($urandom), 24'($urandom), 24'($urandom), 1'b0);
    run_random(60, 1'b0);

    drain_frames();
    if (mismatches == 0 && frames_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
